/* design/vmix_pkg.sv */
`timescale 1ns / 1ps

package vmix_pkg;

	// Default pool and wave table sizes
	localparam int DEFAULT_VOICE_COUNT = 15;
	localparam int DEFAULT_WAVE_SIZE   = 1024;

	// Fixed field widths
	localparam int OP_W       = 3;
	localparam int CHAN_W     = 4;
	localparam int KEY_W      = 7;
	localparam int VEL_W      = 7;
	localparam int WHEEL_W    = 14;
	localparam int WIDX_W     = 10;
	localparam int WAVE_W     = 16;
	localparam int STEP_W     = 26;
	localparam int SAMPLE_W   = 12;
	localparam int STEP_DEPTH = 128;

	// Bend multiplier table, Q1.16
	localparam int BEND_W     = 17;
	localparam int BEND_SEL_W = 6;
	localparam int BEND_DEPTH = 64;

	// Shared multiplier operands and product
	localparam int MUL_A_W = STEP_W + 1;
	localparam int MUL_B_W = BEND_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// One weighted sample after the divide by 16 fits in this many bits
	localparam int TERM_W = WAVE_W + VEL_W + 1 - 4;

	// Output mapping
	localparam int MIX_SHIFT  = 10;
	localparam int MIX_OFFSET = 2048;
	localparam int SAMPLE_MAX = 4095;

	typedef enum logic [OP_W-1:0] {
		OP_TICK      = 3'd0,
		OP_NOTE_ON   = 3'd1,
		OP_NOTE_OFF  = 3'd2,
		OP_BEND      = 3'd3,
		OP_LOAD_WAVE = 3'd4,
		OP_LOAD_STEP = 3'd5
	} op_t;

	// Request into the shared multiply-accumulate unit
	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
		logic                      clr;
		logic                      acc_en;
	} mac_req_t;

	localparam logic [BEND_W-1:0] BEND_Q16 [BEND_DEPTH] = '{
		17'd61858, 17'd61970, 17'd62081, 17'd62194, 17'd62306, 17'd62419, 17'd62531, 17'd62644,
		17'd62757, 17'd62871, 17'd62984, 17'd63098, 17'd63212, 17'd63326, 17'd63441, 17'd63556,
		17'd63670, 17'd63785, 17'd63901, 17'd64016, 17'd64132, 17'd64248, 17'd64364, 17'd64480,
		17'd64596, 17'd64713, 17'd64830, 17'd64947, 17'd65065, 17'd65182, 17'd65300, 17'd65418,
		17'd65536, 17'd65654, 17'd65773, 17'd65892, 17'd66011, 17'd66130, 17'd66250, 17'd66369,
		17'd66489, 17'd66609, 17'd66730, 17'd66850, 17'd66971, 17'd67092, 17'd67213, 17'd67335,
		17'd67456, 17'd67578, 17'd67700, 17'd67823, 17'd67945, 17'd68068, 17'd68191, 17'd68314,
		17'd68438, 17'd68561, 17'd68685, 17'd68809, 17'd68933, 17'd69058, 17'd69183, 17'd69308
	};

endpackage

/* design/vmix_ram.sv */
`timescale 1ns / 1ps

module vmix_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* design/vmix_mac.sv */
`timescale 1ns / 1ps

module vmix_mac import vmix_pkg::*; #(
	parameter int ACC_W = TERM_W + $clog2(DEFAULT_VOICE_COUNT + 1)
) (
	input  logic                     clk,
	input  mac_req_t                 req,
	output logic signed [PROD_W-1:0] prod_s2,
	output logic signed [ACC_W-1:0]  acc_q
);

	// Multiply, then add the product divided by 16 (round down) into the mix
	always_ff @(posedge clk) begin
		prod_s2 <= req.a * req.b;
		if (req.clr) begin
			acc_q <= '0;
		end else if (req.acc_en) begin
			acc_q <= acc_q + $signed(prod_s2[ACC_W+3:4]);
		end
	end

endmodule

/* design/polyphonic_wavetable_voice_mixer_unit.sv */
// Channel  Handshake                  Payload
// -------  -------------------------  ---------------------------------------------
// command  cmd_valid / cmd_stall      op, chan, key, velocity, wheel, wave_index,
//                                     wave_value, step_value
// sample   sample_valid / sample_stall sample (one transaction per tick)
//
// One voice per cycle through the shared multiply-accumulate unit. A tick scans
// every voice, drains and outputs; a pitch wheel scans every voice and drains; note on
// reads the step, then seeks a free voice; note off seeks a match; table loads write on acceptance.
// A tick holds in its output state while the previous sample is still stalled.
// cmd_stall is high while a command is in progress; reset clears the voice pool.
`timescale 1ns / 1ps

module polyphonic_wavetable_voice_mixer_unit import vmix_pkg::*; #(
	parameter int VOICE_COUNT = DEFAULT_VOICE_COUNT,
	parameter int WAVE_SIZE   = DEFAULT_WAVE_SIZE
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic [OP_W-1:0]          op,
	input  logic [CHAN_W-1:0]        chan,
	input  logic [KEY_W-1:0]         key,
	input  logic [VEL_W-1:0]         velocity,
	input  logic [WHEEL_W-1:0]       wheel,
	input  logic [WIDX_W-1:0]        wave_index,
	input  logic signed [WAVE_W-1:0] wave_value,
	input  logic [STEP_W-1:0]        step_value,
	output logic                     sample_valid,
	input  logic                     sample_stall,
	output logic [SAMPLE_W-1:0]      sample
);

	localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int AW    = $clog2(WAVE_SIZE);
	localparam int PW    = AW + 16;
	localparam int CW    = ((PW > STEP_W + 1) ? PW : STEP_W + 1) + 1;
	localparam int IW    = (AW > WIDX_W) ? AW : WIDX_W;
	localparam int ACC_W = TERM_W + $clog2(VOICE_COUNT + 1);
	localparam int KW    = $clog2(STEP_DEPTH);

	localparam logic [CW-1:0]        PHASE_LIMIT = CW'(WAVE_SIZE) << 16;
	localparam logic [PW-1:0]        STEP_MAX    = PW'(PHASE_LIMIT - 1'b1);
	localparam logic [VW-1:0]        LAST_VOICE  = VW'(VOICE_COUNT - 1);
	localparam logic signed [ACC_W:0] MIX_MAX    = (ACC_W + 1)'(SAMPLE_MAX);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_BEND,
		S_DRAIN,
		S_OUT,
		S_NOTE_PREP,
		S_NOTE_ON,
		S_NOTE_OFF
	} state_t;

	// Clamp a step to one below the phase wrap point
	function automatic logic [PW-1:0] limit_step(input logic [CW-1:0] s);
		logic [PW-1:0] r;
		r = (s >= PHASE_LIMIT) ? STEP_MAX : s[PW-1:0];
		return r;
	endfunction

	state_t                 state_q;
	logic [VW-1:0]          vidx_q;
	logic                   drain_q;
	logic                   is_tick_q;
	logic [CHAN_W-1:0]      chan_q;
	logic [KEY_W-1:0]       key_q;
	logic [VEL_W-1:0]       vel_q;
	logic [BEND_W-1:0]      mult_q;
	logic                   sample_valid_q;
	logic [SAMPLE_W-1:0]    sample_q;

	// Voice pool
	logic [VOICE_COUNT-1:0] voice_active_q;
	logic [KEY_W-1:0]       voice_note_q   [VOICE_COUNT];
	logic [CHAN_W-1:0]      voice_chan_q   [VOICE_COUNT];
	logic [VEL_W-1:0]       voice_volume_q [VOICE_COUNT];
	logic [PW-1:0]          voice_step_q   [VOICE_COUNT];
	logic [PW-1:0]          voice_phase_q  [VOICE_COUNT];

	// Pipeline behind the voice scan
	logic                   act_s1;
	logic                   act_s2;
	logic                   match_s1;
	logic                   match_s2;
	logic [VEL_W-1:0]       vol_s1;
	logic [VW-1:0]          vidx_s1;
	logic [VW-1:0]          vidx_s2;

	logic                   accept;
	logic                   cur_active;
	logic                   claim;
	logic                   release_hit;
	logic [PW:0]            phase_sum;
	logic [PW-1:0]          phase_next;
	logic [IW-1:0]          widx_ext;
	logic                   wave_we;
	logic [AW-1:0]          wave_raddr;
	logic [WAVE_W-1:0]      wave_rdata;
	logic                   step_we;
	logic [KW-1:0]          step_raddr;
	logic [STEP_W-1:0]      step_rdata;
	mac_req_t               mac_req;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  mix_shift;
	logic signed [ACC_W:0]    mix_sum;
	logic [SAMPLE_W-1:0]      mix_clamped;

	assign cmd_stall    = (state_q != S_IDLE);
	assign accept       = cmd_valid && !cmd_stall;
	assign sample_valid = sample_valid_q;
	assign sample       = sample_q;

	assign cur_active  = voice_active_q[vidx_q];
	assign claim       = (state_q == S_NOTE_ON) && !cur_active;
	assign release_hit = (state_q == S_NOTE_OFF) && cur_active && (voice_note_q[vidx_q] == key_q);

	// Advance the scanned voice's phase, wrapping once
	always_comb begin
		phase_sum = {1'b0, voice_phase_q[vidx_q]} + {1'b0, voice_step_q[vidx_q]};
		if (phase_sum >= (PW + 1)'(PHASE_LIMIT)) begin
			phase_next = PW'(phase_sum - (PW + 1)'(PHASE_LIMIT));
		end else begin
			phase_next = phase_sum[PW-1:0];
		end
	end

	// Wave table: loaded from the command port, read by the tick scan
	assign widx_ext   = IW'(wave_index);
	assign wave_we    = accept && (op == OP_LOAD_WAVE) && (32'(wave_index) < 32'(WAVE_SIZE));
	assign wave_raddr = phase_next[PW-1:16];

	vmix_ram #(
		.WIDTH (WAVE_W),
		.DEPTH (WAVE_SIZE)
	) u_wave_ram (
		.clk   (clk),
		.we    (wave_we),
		.waddr (widx_ext[AW-1:0]),
		.wdata (wave_value),
		.raddr (wave_raddr),
		.rdata (wave_rdata)
	);

	// Step table: read at the key for note on, at each voice's note for bends
	assign step_we    = accept && (op == OP_LOAD_STEP);
	assign step_raddr = (state_q == S_BEND) ? voice_note_q[vidx_q] : key_q;

	vmix_ram #(
		.WIDTH (STEP_W),
		.DEPTH (STEP_DEPTH)
	) u_step_ram (
		.clk   (clk),
		.we    (step_we),
		.waddr (key),
		.wdata (step_value),
		.raddr (step_raddr),
		.rdata (step_rdata)
	);

	// Feed the shared multiplier: sample times volume, or step times bend
	always_comb begin
		if (is_tick_q) begin
			mac_req.a = MUL_A_W'($signed(wave_rdata));
			mac_req.b = $signed(MUL_B_W'(vol_s1));
		end else begin
			mac_req.a = $signed({1'b0, step_rdata});
			mac_req.b = $signed({1'b0, mult_q});
		end
		mac_req.clr    = accept;
		mac_req.acc_en = act_s2;
	end

	vmix_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk     (clk),
		.req     (mac_req),
		.prod_s2 (prod_s2),
		.acc_q   (acc_q)
	);

	// Map the mix to an unsigned 12-bit sample
	always_comb begin
		mix_shift = acc_q >>> MIX_SHIFT;
		mix_sum   = (ACC_W + 1)'(mix_shift) + (ACC_W + 1)'(MIX_OFFSET);
		if (mix_sum < 0) begin
			mix_clamped = '0;
		end else if (mix_sum > MIX_MAX) begin
			mix_clamped = SAMPLE_W'(SAMPLE_MAX);
		end else begin
			mix_clamped = mix_sum[SAMPLE_W-1:0];
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			vidx_q         <= '0;
			drain_q        <= 1'b0;
			is_tick_q      <= 1'b0;
			chan_q         <= '0;
			key_q          <= '0;
			vel_q          <= '0;
			mult_q         <= '0;
			sample_valid_q <= 1'b0;
			sample_q       <= '0;
		end else begin
			// Drop a delivered sample unless the output step replaces it
			if (sample_valid_q && !sample_stall && (state_q != S_OUT)) begin
				sample_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						vidx_q    <= '0;
						drain_q   <= 1'b0;
						is_tick_q <= (op == OP_TICK);
						chan_q    <= chan;
						key_q     <= key;
						vel_q     <= velocity;
						mult_q    <= BEND_Q16[wheel[WHEEL_W-1 -: BEND_SEL_W]];
						case (op)
							OP_TICK:     state_q <= S_TICK;
							OP_NOTE_ON:  state_q <= (velocity != '0) ? S_NOTE_PREP : S_NOTE_OFF;
							OP_NOTE_OFF: state_q <= S_NOTE_OFF;
							OP_BEND:     state_q <= S_BEND;
							default:     state_q <= S_IDLE;
						endcase
					end
				end
				S_TICK, S_BEND: begin
					if (vidx_q == LAST_VOICE) begin
						state_q <= S_DRAIN;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= is_tick_q ? S_OUT : S_IDLE;
					end
				end
				S_OUT: begin
					if (!sample_valid_q || !sample_stall) begin
						sample_q       <= mix_clamped;
						sample_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_NOTE_PREP: begin
					state_q <= S_NOTE_ON;
				end
				S_NOTE_ON: begin
					if (claim || (vidx_q == LAST_VOICE)) begin
						state_q <= S_IDLE;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				S_NOTE_OFF: begin
					if (release_hit || (vidx_q == LAST_VOICE)) begin
						state_q <= S_IDLE;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Track which voice of the scan is in each stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1   <= 1'b0;
			act_s2   <= 1'b0;
			match_s1 <= 1'b0;
			match_s2 <= 1'b0;
			vol_s1   <= '0;
			vidx_s1  <= '0;
			vidx_s2  <= '0;
		end else begin
			act_s1   <= (state_q == S_TICK) && cur_active;
			act_s2   <= act_s1;
			match_s1 <= (state_q == S_BEND) && cur_active && (voice_chan_q[vidx_q] == chan_q);
			match_s2 <= match_s1;
			vol_s1   <= voice_volume_q[vidx_q];
			vidx_s1  <= vidx_q;
			vidx_s2  <= vidx_s1;
		end
	end

	// Start and stop voices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_active_q <= '0;
		end else if (claim) begin
			voice_active_q[vidx_q] <= 1'b1;
		end else if (release_hit) begin
			voice_active_q[vidx_q] <= 1'b0;
		end
	end

	// Voice payload; a released voice gets its step again at its next note on
	always_ff @(posedge clk) begin
		if (claim) begin
			voice_note_q[vidx_q]   <= key_q;
			voice_volume_q[vidx_q] <= vel_q;
			voice_chan_q[vidx_q]   <= chan_q;
			voice_phase_q[vidx_q]  <= '0;
			voice_step_q[vidx_q]   <= limit_step(CW'(step_rdata));
		end
		if ((state_q == S_TICK) && cur_active) begin
			voice_phase_q[vidx_q] <= phase_next;
		end
		if (match_s2) begin
			voice_step_q[vidx_s2] <= limit_step(prod_s2[16+CW-1:16]);
		end
	end

	// A scan leaves only after its last voice
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && ($past(state_q) == S_TICK || $past(state_q) == S_BEND))
			|-> $past(vidx_q) == LAST_VOICE)
		else $error("voice scan ended early");

	// At most one voice starts or stops per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(voice_active_q ^ $past(voice_active_q)) <= 1)
		else $error("more than one voice changed state");

	// A new sample comes only from the output step of a tick
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid_q) |-> ($past(state_q) == S_OUT && $past(is_tick_q)))
		else $error("sample issued outside a tick");

	// Accumulation happens only while a tick scans or drains
	assert property (@(posedge clk) disable iff (!arst_n)
		act_s2 |-> (is_tick_q && (state_q == S_TICK || state_q == S_DRAIN)))
		else $error("mix accumulated outside a tick");

endmodule

/* sim/polyphonic_wavetable_voice_mixer_unit_tb.sv */
`timescale 1ns / 1ps

module polyphonic_wavetable_voice_mixer_unit_tb import vmix_pkg::*; ();

	localparam int VOICE_N = DEFAULT_VOICE_COUNT;
	localparam int WAVE_N = DEFAULT_WAVE_SIZE;
	localparam longint PHASE_WRAP = longint'(WAVE_N) << 16;
	localparam int HOT_KEYS = 6;
	localparam int WATCHDOG_LIMIT = 3000;

	// Opcodes the block must ignore
	localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
	localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [CHAN_W-1:0]        chan;
		logic [KEY_W-1:0]         key;
		logic [VEL_W-1:0]         velocity;
		logic [WHEEL_W-1:0]       wheel;
		logic [WIDX_W-1:0]        wave_index;
		logic signed [WAVE_W-1:0] wave_value;
		logic [STEP_W-1:0]        step_value;
	} synth_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	synth_cmd_t drv = '0;
	logic sample_valid;
	logic sample_stall = 1'b0;
	logic [SAMPLE_W-1:0] sample;

	synth_cmd_t pending_cmds[$];
	logic [SAMPLE_W-1:0] exp_samples[$];
	logic [SAMPLE_W-1:0] want_sample;
	logic [KEY_W-1:0] hot_keys [HOT_KEYS];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int errors = 0;
	int idle_run = 0;

	// Voice pool and tables as the block should hold them
	logic              v_on    [VOICE_N] = '{default: 1'b0};
	logic [KEY_W-1:0]  v_note  [VOICE_N] = '{default: '0};
	logic [CHAN_W-1:0] v_chan  [VOICE_N] = '{default: '0};
	logic [VEL_W-1:0]  v_vol   [VOICE_N] = '{default: '0};
	logic [STEP_W-1:0] v_step  [VOICE_N] = '{default: '0};
	logic [STEP_W-1:0] v_phase [VOICE_N] = '{default: '0};
	logic signed [WAVE_W-1:0] wave_mem [WAVE_N];
	logic [STEP_W-1:0] step_mem [STEP_DEPTH];

	always #1 clk = ~clk;

	polyphonic_wavetable_voice_mixer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.op(drv.op),
		.chan(drv.chan),
		.key(drv.key),
		.velocity(drv.velocity),
		.wheel(drv.wheel),
		.wave_index(drv.wave_index),
		.wave_value(drv.wave_value),
		.step_value(drv.step_value),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample)
	);

	function automatic logic [STEP_W-1:0] fit_step(longint s);
		if (s >= PHASE_WRAP)
			s = PHASE_WRAP - 1;
		return s[STEP_W-1:0];
	endfunction

	// Free the first sounding voice on this key, reloading its step
	function automatic void release_note(logic [KEY_W-1:0] k);
		for (int v = 0; v < VOICE_N; v++) begin
			if (v_on[v] && v_note[v] == k) begin
				v_on[v] = 1'b0;
				v_chan[v] = '0;
				v_step[v] = fit_step(step_mem[k]);
				return;
			end
		end
	endfunction

	// Apply one accepted command to the voice pool; a tick queues its mixed sample
	function automatic void synth_update(synth_cmd_t c);
		int acc;
		int p;
		int term;
		longint prod;
		logic [BEND_SEL_W-1:0] sel;
		case (c.op)
			OP_TICK: begin
				acc = 0;
				for (int v = 0; v < VOICE_N; v++) begin
					if (v_on[v]) begin
						p = int'(v_phase[v]) + int'(v_step[v]);
						if (p >= PHASE_WRAP)
							p = p - int'(PHASE_WRAP);
						v_phase[v] = p[STEP_W-1:0];
						term = (int'(wave_mem[p >> 16]) * int'(v_vol[v])) >>> 4;
						acc = acc + term;
					end
				end
				acc = (acc >>> MIX_SHIFT) + MIX_OFFSET;
				if (acc > SAMPLE_MAX)
					acc = SAMPLE_MAX;
				else if (acc < 0)
					acc = 0;
				exp_samples.push_back(acc[SAMPLE_W-1:0]);
			end
			OP_NOTE_ON: begin
				if (c.velocity == '0) begin
					release_note(c.key);
				end else begin
					for (int v = 0; v < VOICE_N; v++) begin
						if (!v_on[v]) begin
							v_note[v] = c.key;
							v_step[v] = fit_step(step_mem[c.key]);
							v_phase[v] = '0;
							v_vol[v] = c.velocity;
							v_chan[v] = c.chan;
							v_on[v] = 1'b1;
							break;
						end
					end
				end
			end
			OP_NOTE_OFF: release_note(c.key);
			OP_BEND: begin
				sel = c.wheel[WHEEL_W-1 -: BEND_SEL_W];
				for (int v = 0; v < VOICE_N; v++) begin
					if (v_on[v] && v_chan[v] == c.chan) begin
						prod = (longint'(step_mem[v_note[v]]) * longint'(BEND_Q16[sel])) >> 16;
						v_step[v] = fit_step(prod);
					end
				end
			end
			OP_LOAD_WAVE: wave_mem[c.wave_index] = c.wave_value;
			OP_LOAD_STEP: step_mem[c.key] = c.step_value;
			default: ;
		endcase
	endfunction

	// Random payload in every field, with the given opcode
	function automatic synth_cmd_t with_op(logic [OP_W-1:0] o);
		synth_cmd_t c;
		c.op = o;
		c.chan = CHAN_W'($urandom);
		c.key = KEY_W'($urandom);
		c.velocity = VEL_W'($urandom);
		c.wheel = WHEEL_W'($urandom);
		c.wave_index = WIDX_W'($urandom);
		c.wave_value = WAVE_W'($urandom);
		c.step_value = STEP_W'($urandom);
		return c;
	endfunction

	// Mostly meaningful play: notes on a few hot keys, bends on a few channels, ticks
	function automatic synth_cmd_t rand_cmd();
		synth_cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			c = with_op(OP_TICK);
		else if (pick < 58)
			c = with_op(OP_NOTE_ON);
		else if (pick < 74)
			c = with_op(OP_NOTE_OFF);
		else if (pick < 84)
			c = with_op(OP_BEND);
		else if (pick < 91)
			c = with_op(OP_LOAD_WAVE);
		else if (pick < 97)
			c = with_op(OP_LOAD_STEP);
		else
			c = with_op(pick[0] ? OP_RESERVED_A : OP_RESERVED_B);
		if ((c.op == OP_NOTE_ON || c.op == OP_NOTE_OFF) && $urandom_range(0, 9) < 8)
			c.key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
		if ((c.op == OP_NOTE_ON || c.op == OP_BEND) && $urandom_range(0, 9) < 8)
			c.chan = CHAN_W'($urandom_range(0, 3));
		if (c.op == OP_NOTE_ON && $urandom_range(0, 99) < 8)
			c.velocity = '0;
		return c;
	endfunction

	// Queue one stretch of random traffic under the given idling
	task automatic run_segment(input int count, input int send_pct, input int recv_pct,
			input int hold);
		while (pending_cmds.size() != 0)
			@(negedge clk);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		hold_left = hold;
		foreach (hot_keys[i])
			hot_keys[i] = KEY_W'($urandom);
		repeat (count)
			pending_cmds.push_back(rand_cmd());
	endtask

	// Hold off new commands until every pending sample has come back
	task automatic drain_all();
		while (pending_cmds.size() != 0 || cmd_valid)
			@(negedge clk);
		while (exp_samples.size() != 0)
			@(negedge clk);
	endtask

	// Command driver: predict on each accepted transaction, then offer the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			drv <= '0;
		end else begin
			if (cmd_valid && !cmd_stall)
				synth_update(drv);
			if (!cmd_valid || !cmd_stall) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drv <= pending_cmds.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Sample monitor: compare each transaction, then pick the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_stall <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall) begin
				if (exp_samples.size() == 0) begin
					$display("%0t: sample %0d with no tick pending", $time, sample);
					errors = errors + 1;
				end else begin
					want_sample = exp_samples.pop_front();
					if (sample !== want_sample) begin
						$display("%0t: sample mismatch, expected %0d, actual %0d",
							$time, want_sample, sample);
						errors = errors + 1;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				sample_stall <= 1'b1;
			end else begin
				sample_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Stop a hung run: too many cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (sample_valid && !sample_stall)) begin
				idle_run <= 0;
			end else if (idle_run >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_run <= idle_run + 1;
			end
		end
	end

	initial begin
		synth_cmd_t c;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty pool mixes to mid-scale; reserved opcodes do nothing
		pending_cmds.push_back(with_op(OP_TICK));
		pending_cmds.push_back(with_op(OP_RESERVED_A));
		pending_cmds.push_back(with_op(OP_RESERVED_B));

		// Table extremes: first and last wave entries, zero and largest step
		c = with_op(OP_LOAD_WAVE);
		c.wave_index = '0;
		c.wave_value = 16'sh7FFF;
		pending_cmds.push_back(c);
		c = with_op(OP_LOAD_WAVE);
		c.wave_index = WIDX_W'(WAVE_N - 1);
		c.wave_value = 16'sh8000;
		pending_cmds.push_back(c);
		c = with_op(OP_LOAD_STEP);
		c.key = '0;
		c.step_value = '0;
		pending_cmds.push_back(c);
		c = with_op(OP_LOAD_STEP);
		c.key = '1;
		c.step_value = '1;
		pending_cmds.push_back(c);

		// Largest step lands on the last wave entry; bend down, then saturate back up
		c = with_op(OP_NOTE_ON);
		c.key = '1;
		c.velocity = '1;
		c.chan = '1;
		pending_cmds.push_back(c);
		c = with_op(OP_BEND);
		c.chan = '1;
		c.wheel = '0;
		pending_cmds.push_back(c);
		c = with_op(OP_BEND);
		c.chan = '1;
		c.wheel = '1;
		pending_cmds.push_back(c);
		pending_cmds.push_back(with_op(OP_TICK));

		// Release with no match, then release by zero velocity
		c = with_op(OP_NOTE_OFF);
		c.key = KEY_W'(5);
		pending_cmds.push_back(c);
		c = with_op(OP_NOTE_ON);
		c.key = '1;
		c.velocity = '0;
		pending_cmds.push_back(c);

		// Fill the pool at full volume, drop one more note, clip high then low
		repeat (VOICE_N + 1) begin
			c = with_op(OP_NOTE_ON);
			c.key = '0;
			c.velocity = '1;
			pending_cmds.push_back(c);
		end
		pending_cmds.push_back(with_op(OP_TICK));
		c = with_op(OP_LOAD_WAVE);
		c.wave_index = '0;
		c.wave_value = 16'sh8000;
		pending_cmds.push_back(c);
		pending_cmds.push_back(with_op(OP_TICK));

		// Write every table entry so any phase and key can be read, then empty the pool
		for (int i = 0; i < WAVE_N; i++) begin
			c = with_op(OP_LOAD_WAVE);
			c.wave_index = WIDX_W'(i);
			pending_cmds.push_back(c);
		end
		for (int k = 0; k < STEP_DEPTH; k++) begin
			c = with_op(OP_LOAD_STEP);
			c.key = KEY_W'(k);
			pending_cmds.push_back(c);
		end
		repeat (VOICE_N) begin
			c = with_op(OP_NOTE_OFF);
			c.key = '0;
			pending_cmds.push_back(c);
		end

		// Random play under each idling pattern
		run_segment(140, 0, 0, 0);
		run_segment(120, 72, 0, 0);
		drain_all();
		run_segment(120, 0, 72, 0);
		run_segment(140, 19, 19, 0);
		// Long receiver hold-off so the block backs up into the command side
		run_segment(80, 0, 0, 300);
		run_segment(50, 0, 0, 0);

		drain_all();
		repeat (40)
			@(negedge clk);
		if (exp_samples.size() != 0) begin
			$display("%0t: %0d expected samples never arrived, next expected %0d",
				$time, exp_samples.size(), exp_samples[0]);
			errors = errors + 1;
		end
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
